FILE: hdl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg: shared types and constants for the k-nearest-neighbour classifier
// Field widths, register indexes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package knn_pkg;

  // Field widths fixed by the item formats
  localparam int COORD_W = 5;
  localparam int SLOT_W  = 4;
  localparam int REG_W   = 5;
  localparam int VOTE_W  = 5;
  localparam int DIST_W  = 2 * COORD_W + 1;

  // Default table depth
  localparam int DEF_MAX_SAMPLES = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEIGHBOR_COUNT = 1'b0,
    REG_SAMPLES_IN_USE = 1'b1
  } knn_reg_t;

  // Item kinds carried in the input tuser
  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } knn_mode_t;

  // Class labels
  localparam logic CLASS_P = 1'b0;
  localparam logic CLASS_Q = 1'b1;

  // One sample table entry
  typedef struct packed {
    logic             label;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } knn_sample_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_VOTE,
    ST_DONE
  } knn_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_en;   // write the input sample into the table
    logic query_en;  // latch query point, clear list, votes and index
    logic rd_en;     // read table entry at the index, step the index
    logic cnt_clr;   // clear the index
    logic vote_en;   // count head of the sorted list, shift it, step index
    logic out_load;  // move the votes into the output register
  } knn_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // every sample in use has been read
    logic vote_done;  // k entries have voted
    logic out_free;   // output register can take a result this cycle
  } knn_status_t;

endpackage

FILE: hdl/knn_two_class_classifier.sv
// ----------------------------------------------------------------------------
// knn_two_class_classifier: two-class k-nearest-neighbour classifier
// Loads labelled samples into a table and classifies query points by the
// vote of the k nearest samples in squared Euclidean distance.
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes x, y and class into a table slot; a load to
// a slot at or above MAX_SAMPLES is dropped. Loads give no result. A query
// item (tuser 1) uses n, the samples in use (clamped to MAX_SAMPLES), and k,
// the neighbour count (clamped to n): one table read per cycle feeds a
// two-stage distance pipeline into an insertion-sorted list, then the k
// nearest are counted one per cycle from the head of the list. Distance
// ties favour the lower slot, and a vote tie gives class Q. Only one item
// is worked on at a time; a finished result sits in the output register
// while the next item is taken. Slots must be loaded before a query reads
// them. Write configuration only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module knn_two_class_classifier import knn_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,   // slot[3:0], point_x[8:4], point_y[13:9],
                                           // sample_class[14], zero[15]
  input  logic                 in_tuser,   // mode: 0 load, 1 query
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // predicted_class[0], p_votes[5:1],
                                           // q_votes[10:6], zero[15:11]
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  knn_cmd_t          cmd;
  knn_status_t       status;
  logic              pred_class;
  logic [VOTE_W-1:0] p_votes, q_votes;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  knn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  knn_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_slot             (in_tdata[3:0]),
    .in_point_x          (in_tdata[8:4]),
    .in_point_y          (in_tdata[13:9]),
    .in_sample_class     (in_tdata[14]),
    .cmd                 (cmd),
    .status              (status),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_predicted_class (pred_class),
    .out_p_votes         (p_votes),
    .out_q_votes         (q_votes)
  );

  // Result packing
  assign out_tdata = {5'd0, q_votes, p_votes, pred_class};

endmodule

FILE: hdl/knn_ctrl.sv
// ----------------------------------------------------------------------------
// knn_ctrl: sequencing state machine
// Takes items, walks the table for a query, waits for the distance pipeline
// to empty, steps the vote count and hands the result to the output register.
// ----------------------------------------------------------------------------
module knn_ctrl import knn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tuser,
  output logic        in_tready,
  input  knn_status_t status,
  output knn_cmd_t    cmd
);

  knn_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (knn_mode_t'(in_tuser) == MODE_QUERY) begin
            cmd.query_en = 1'b1;
            state_nxt    = ST_SCAN;
          end else begin
            cmd.load_en = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_DRAIN1;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_DRAIN1: begin
        state_nxt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        cmd.cnt_clr = 1'b1;
        state_nxt   = ST_VOTE;
      end
      ST_VOTE: begin
        if (status.vote_done) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.vote_en = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/knn_dp.sv
// ----------------------------------------------------------------------------
// knn_dp: sample table, distance pipeline, sorted neighbour list and votes
// Distances stream in one per cycle and are insertion-sorted into a row of
// registers; the nearest k are then shifted out of the head and counted.
// ----------------------------------------------------------------------------
module knn_dp import knn_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data,
  // input item fields
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [COORD_W-1:0]    in_point_x,
  input  logic [COORD_W-1:0]    in_point_y,
  input  logic                  in_sample_class,
  // controller
  input  knn_cmd_t              cmd,
  output knn_status_t           status,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_predicted_class,
  output logic [VOTE_W-1:0]     out_p_votes,
  output logic [VOTE_W-1:0]     out_q_votes
);

  localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;

  // Configuration registers
  logic [REG_W-1:0] neighbor_count_r;
  logic [REG_W-1:0] samples_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neighbor_count_r <= REG_W'(1);
      samples_in_use_r <= REG_W'(10);
    end else if (cfg_we) begin
      case (knn_reg_t'(cfg_index))
        REG_NEIGHBOR_COUNT: neighbor_count_r <= cfg_data;
        REG_SAMPLES_IN_USE: samples_in_use_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sample count and k, both clamped
  logic [CMP_W-1:0] siu_ext, nc_ext, n_ext, k_ext;
  logic [CNT_W-1:0] n_eff, k_eff;

  always_comb begin
    siu_ext = CMP_W'(samples_in_use_r);
    nc_ext  = CMP_W'(neighbor_count_r);
    n_ext   = (32'(siu_ext) > MAX_SAMPLES) ? CMP_W'(MAX_SAMPLES) : siu_ext;
    k_ext   = (nc_ext > n_ext) ? n_ext : nc_ext;
    n_eff   = n_ext[CNT_W-1:0];
    k_eff   = k_ext[CNT_W-1:0];
  end

  // Walk index shared by the table scan and the vote count
  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.query_en || cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.rd_en || cmd.vote_en) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Sample table
  knn_sample_t mem [MAX_SAMPLES];
  knn_sample_t rd_data_r;
  knn_sample_t wr_data;
  logic        wr_ok;

  assign wr_data = '{label: in_sample_class, y: in_point_y, x: in_point_x};
  assign wr_ok   = 32'(in_slot) < MAX_SAMPLES;

  always_ff @(posedge clk) begin
    if (cmd.load_en && wr_ok) begin
      mem[AW'(in_slot)] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cnt_r[AW-1:0]];
    end
  end

  // Query point
  logic [COORD_W-1:0] qx_r, qy_r;

  always_ff @(posedge clk) begin
    if (cmd.query_en) begin
      qx_r <= in_point_x;
      qy_r <= in_point_y;
    end
  end

  // Distance pipeline: read stage, then squared distance register
  logic               s1_v_r, s2_v_r;
  logic [DIST_W-1:0]  s2_dist_r;
  logic               s2_lbl_r;
  logic [COORD_W-1:0] dx, dy;
  logic [DIST_W-1:0]  sq_dist;

  always_comb begin
    dx      = (rd_data_r.x > qx_r) ? rd_data_r.x - qx_r : qx_r - rd_data_r.x;
    dy      = (rd_data_r.y > qy_r) ? rd_data_r.y - qy_r : qy_r - rd_data_r.y;
    sq_dist = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd_en;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_dist_r <= sq_dist;
      s2_lbl_r  <= rd_data_r.label;
    end
  end

  // Sorted neighbour list, nearest at the head. A new distance goes after
  // every entry that is not larger, so ties keep the lower slot first.
  logic [DIST_W-1:0] ld_r   [MAX_SAMPLES];
  logic              ll_r   [MAX_SAMPLES];
  logic              lv_r   [MAX_SAMPLES];
  logic              goes_after [MAX_SAMPLES];

  always_comb begin
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      goes_after[i] = !lv_r[i] || (s2_dist_r < ld_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        lv_r[i] <= 1'b0;
      end
    end else if (cmd.query_en) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        lv_r[i] <= 1'b0;
      end
    end else if (s2_v_r) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        if (goes_after[i]) begin
          if (i == 0 || !goes_after[(i == 0) ? 0 : i - 1]) begin
            lv_r[i] <= 1'b1;
          end else begin
            lv_r[i] <= lv_r[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (cmd.vote_en) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        lv_r[i] <= (i == MAX_SAMPLES - 1) ? 1'b0 : lv_r[(i == MAX_SAMPLES - 1) ? i : i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        if (goes_after[i]) begin
          if (i == 0 || !goes_after[(i == 0) ? 0 : i - 1]) begin
            ld_r[i] <= s2_dist_r;
            ll_r[i] <= s2_lbl_r;
          end else begin
            ld_r[i] <= ld_r[(i == 0) ? 0 : i - 1];
            ll_r[i] <= ll_r[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end else if (cmd.vote_en) begin
      for (int i = 0; i < MAX_SAMPLES - 1; i++) begin
        ld_r[i] <= ld_r[i + 1];
        ll_r[i] <= ll_r[i + 1];
      end
    end
  end

  // Vote counters, fed from the list head
  logic [VOTE_W-1:0] pv_r, qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      qv_r <= '0;
    end else if (cmd.query_en) begin
      pv_r <= '0;
      qv_r <= '0;
    end else if (cmd.vote_en && lv_r[0]) begin
      if (ll_r[0] == CLASS_P) begin
        pv_r <= pv_r + VOTE_W'(1);
      end else begin
        qv_r <= qv_r + VOTE_W'(1);
      end
    end
  end

  // Output register
  logic              out_valid_r;
  logic              out_cls_r;
  logic [VOTE_W-1:0] out_pv_r, out_qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cls_r <= (pv_r > qv_r) ? CLASS_P : CLASS_Q;
      out_pv_r  <= pv_r;
      out_qv_r  <= qv_r;
    end
  end

  assign out_tvalid          = out_valid_r;
  assign out_predicted_class = out_cls_r;
  assign out_p_votes         = out_pv_r;
  assign out_q_votes         = out_qv_r;

  // Status back to the controller
  assign status.scan_done = (cnt_r >= n_eff);
  assign status.vote_done = (cnt_r >= k_eff);
  assign status.out_free  = !out_valid_r || out_tready;

endmodule
